// ===== rtl/tps_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Traffic phase sequencer package
// Widths, register indexes, timing constants and helper functions shared by
// the sequencer RTL.
// ---------------------------------------------------------------------------
package tps_pkg;

    localparam int CH_W      = 10;
    localparam int PHASE_W   = 2;
    localparam int COUNT_W   = 8;
    localparam int DIST_W    = 8;
    localparam int NEAR_W    = 7;
    localparam int RANGE_W   = 24;
    localparam int PATTERN_W = 40;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = PATTERN_W;

    localparam logic [CFG_IDX_W-1:0] REG_GREEN_PATTERN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL_PHASE0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL_PHASE1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL_PHASE2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL_PHASE3  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT    = 3'd5;

    localparam logic [PATTERN_W-1:0] GREEN_PATTERN_RESET = 40'd473354833093;
    localparam logic [COUNT_W-1:0]   DWELL_RESET         = 8'd10;
    localparam logic [NEAR_W-1:0]    NEAR_LIMIT_RESET    = 7'd20;
    localparam logic [DIST_W-1:0]    DIST_RESET          = 8'd255;

    localparam logic [PHASE_W-1:0] PHASE_0 = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_1 = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_2 = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_3 = 2'd3;

    localparam logic [COUNT_W-1:0] BLINK_START = 8'd3;
    localparam logic [COUNT_W-1:0] CUT_TIME    = 8'd3;
    localparam logic [COUNT_W-1:0] HOLD_TIME   = 8'd6;

    localparam logic REQ_HALF   = 1'b0;
    localparam logic REQ_SECOND = 1'b1;

    // Division by 10000 as a multiply by ceil(2^34 / 10000) and a shift.
    // The result is exact over the whole 24-bit range.
    localparam int DIV_SHIFT  = 34;
    localparam int RECIP_W    = 21;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 21'd1717987;
    localparam int PROD_W     = RANGE_W + RECIP_W;
    localparam int QUOT_W     = PROD_W - DIV_SHIFT;
    localparam logic [QUOT_W-1:0] DIST_CAP = 11'd100;

    function automatic logic [CH_W-1:0] mask_of(input logic [PATTERN_W-1:0] pattern,
                                                input logic [PHASE_W-1:0] p);
        logic [CH_W-1:0] m;
        begin
            m = CH_W'(pattern >> (CH_W * int'(p)));
            return m;
        end
    endfunction

    function automatic logic [DIST_W-1:0] range_to_distance(input logic [RANGE_W-1:0] raw);
        logic [PROD_W-1:0] prod;
        logic [QUOT_W-1:0] quot;
        begin
            prod = PROD_W'(raw) * PROD_W'(DIV_RECIP);
            quot = prod[PROD_W-1:DIV_SHIFT];
            if (quot > DIST_CAP)
            begin
                quot = DIST_CAP;
            end
            return quot[DIST_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/traffic_phase_sequencer_with_preempt.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Traffic phase sequencer with train preemption
// Four-phase, ten-channel light sequencer driven by half-second and
// one-second ticks, with a crossing indicator and train distance sampling.
// ---------------------------------------------------------------------------
// A word is captured in the input register when it is accepted, and its result
// is loaded into the output register when the word advances, which an output
// stall can hold back.
// Throughput: one word per cycle unless the output stalls; the state update is
// one pass of shallow logic and one constant multiply between the two registers.
// Reset: asynchronous active low; state and settings reset, data registers do not.
module traffic_phase_sequencer_with_preempt
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [tps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tps_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [tps_pkg::RANGE_W-1:0]   range_raw,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tps_pkg::CH_W-1:0]      lamps,
    output logic                          crossing_on,
    output logic [tps_pkg::DIST_W-1:0]    shown_distance,
    output logic [tps_pkg::PHASE_W-1:0]   current_phase,
    output logic [tps_pkg::COUNT_W-1:0]   seconds_left
);
    import tps_pkg::*;

    logic [PATTERN_W-1:0] green_pattern_reg;
    logic [COUNT_W-1:0]   dwell_reg [4];
    logic [NEAR_W-1:0]    near_limit_reg;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [PHASE_W-1:0] upcoming_reg, upcoming_next;
    logic [COUNT_W-1:0] countdown_reg, countdown_next;
    logic               blink_reg, blink_next;
    logic [DIST_W-1:0]  distance_reg, distance_next;
    logic [CH_W-1:0]    lamp_bits_reg, lamp_bits_next;
    logic               crossing_reg, crossing_next;

    logic               in_full_reg;
    logic               req_type_reg;
    logic [RANGE_W-1:0] range_raw_reg;

    logic               out_valid_reg;
    logic [CH_W-1:0]    lamps_reg;
    logic               crossing_on_reg;
    logic [DIST_W-1:0]  shown_distance_reg;
    logic [PHASE_W-1:0] current_phase_reg;
    logic [COUNT_W-1:0] seconds_left_reg;

    logic advance;
    logic in_take;
    logic near;
    logic mid_old;
    logic [CH_W-1:0] leaving;
    logic [COUNT_W-1:0] count_dec;

    assign advance  = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign near    = {1'b0, distance_reg[DIST_W-2:0]} < {1'b0, near_limit_reg}
                     && !distance_reg[DIST_W-1];
    assign mid_old = (phase_reg == PHASE_1) || (phase_reg == PHASE_2);
    assign leaving = mask_of(green_pattern_reg, phase_reg)
                     & ~mask_of(green_pattern_reg, upcoming_reg);
    assign count_dec = countdown_reg - 8'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        upcoming_next  = upcoming_reg;
        countdown_next = countdown_reg;
        blink_next     = blink_reg;
        distance_next  = distance_reg;
        lamp_bits_next = lamp_bits_reg;
        crossing_next  = crossing_reg;
        case (req_type_reg)
            REQ_HALF:
            begin
                if (countdown_reg == '0)
                begin
                    if (!(mid_old && near) || (upcoming_reg == PHASE_3))
                    begin
                        crossing_next = 1'b0;
                    end
                    phase_next     = upcoming_reg;
                    upcoming_next  = upcoming_reg + 2'd1;
                    lamp_bits_next = mask_of(green_pattern_reg, upcoming_reg);
                    countdown_next = dwell_reg[upcoming_reg];
                end
                else if (countdown_reg < BLINK_START)
                begin
                    if (blink_reg)
                    begin
                        lamp_bits_next = lamp_bits_reg | leaving;
                    end
                    else
                    begin
                        lamp_bits_next = lamp_bits_reg & ~leaving;
                    end
                    blink_next = !blink_reg;
                end
                if ((phase_next == PHASE_1) || (phase_next == PHASE_2))
                begin
                    crossing_next = near;
                end
            end
            REQ_SECOND:
            begin
                if (countdown_reg != '0)
                begin
                    countdown_next = count_dec;
                    if ((count_dec > CUT_TIME) && near
                        && ((phase_reg == PHASE_0) || (phase_reg == PHASE_3)))
                    begin
                        countdown_next = CUT_TIME;
                        upcoming_next  = PHASE_1;
                    end
                    else if ((count_dec < HOLD_TIME) && near && (phase_reg == PHASE_2))
                    begin
                        countdown_next = HOLD_TIME;
                    end
                end
                distance_next = range_to_distance(range_raw_reg);
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            green_pattern_reg <= GREEN_PATTERN_RESET;
            dwell_reg[0]      <= DWELL_RESET;
            dwell_reg[1]      <= DWELL_RESET;
            dwell_reg[2]      <= DWELL_RESET;
            dwell_reg[3]      <= DWELL_RESET;
            near_limit_reg    <= NEAR_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GREEN_PATTERN: green_pattern_reg <= cfg_data[PATTERN_W-1:0];
                REG_DWELL_PHASE0:  dwell_reg[0]      <= cfg_data[COUNT_W-1:0];
                REG_DWELL_PHASE1:  dwell_reg[1]      <= cfg_data[COUNT_W-1:0];
                REG_DWELL_PHASE2:  dwell_reg[2]      <= cfg_data[COUNT_W-1:0];
                REG_DWELL_PHASE3:  dwell_reg[3]      <= cfg_data[COUNT_W-1:0];
                REG_NEAR_LIMIT:    near_limit_reg    <= cfg_data[NEAR_W-1:0];
                default:           near_limit_reg    <= near_limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PHASE_0;
            upcoming_reg  <= PHASE_1;
            countdown_reg <= '0;
            blink_reg     <= 1'b0;
            distance_reg  <= DIST_RESET;
            lamp_bits_reg <= '0;
            crossing_reg  <= 1'b0;
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_full_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_full_reg <= 1'b0;
            end

            if (advance)
            begin
                phase_reg     <= phase_next;
                upcoming_reg  <= upcoming_next;
                countdown_reg <= countdown_next;
                blink_reg     <= blink_next;
                distance_reg  <= distance_next;
                lamp_bits_reg <= lamp_bits_next;
                crossing_reg  <= crossing_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_type_reg  <= req_type;
            range_raw_reg <= range_raw;
        end
        if (advance)
        begin
            lamps_reg          <= lamp_bits_next;
            crossing_on_reg    <= crossing_next;
            shown_distance_reg <= distance_next;
            current_phase_reg  <= phase_next;
            seconds_left_reg   <= countdown_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign lamps          = lamps_reg;
    assign crossing_on    = crossing_on_reg;
    assign shown_distance = shown_distance_reg;
    assign current_phase  = current_phase_reg;
    assign seconds_left   = seconds_left_reg;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Traffic phase sequencer testbench
// Feeds half-second and one-second tick words to the sequencer and predicts
// the lamps, crossing flag, distance, phase and countdown of every result
// word. Checks each result field by field. The stimulus is a short directed
// opening, then random tick sequences under several register settings,
// with random input gaps and output stalls outside one quiet stretch.
// ---------------------------------------------------------------------------
module testbench;

    import tps_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int IDLE_PERCENT   = 28;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 40;
    localparam int RANGE_STEP     = 10000;
    localparam int DIST_MAX       = 100;
    localparam int RANGE_MAX      = 24'hFFFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [CH_W-1:0]    lamp_word;
        logic               crossing;
        logic [DIST_W-1:0]  distance;
        logic [PHASE_W-1:0] phase;
        logic [COUNT_W-1:0] seconds;
    } light_word_t;

    typedef struct packed {
        logic               req;
        logic [RANGE_W-1:0] raw;
    } tick_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  req_type = REQ_HALF;
    logic [RANGE_W-1:0]    range_raw = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [CH_W-1:0]       lamps;
    logic                  crossing_on;
    logic [DIST_W-1:0]     shown_distance;
    logic [PHASE_W-1:0]    current_phase;
    logic [COUNT_W-1:0]    seconds_left;

    // Predictor copy of the registers.
    logic [PATTERN_W-1:0] set_green;
    logic [COUNT_W-1:0]   set_dwell [4];
    logic [NEAR_W-1:0]    set_near;

    // Predictor copy of the sequencer state.
    logic [PHASE_W-1:0] seq_phase;
    logic [PHASE_W-1:0] seq_next;
    logic [COUNT_W-1:0] seq_count;
    logic               seq_blink;
    logic [DIST_W-1:0]  seq_dist;
    logic [CH_W-1:0]    seq_lamps;
    logic               seq_cross;

    tick_word_t  tick_queue [$];
    light_word_t pending_lights [$];

    logic in_fire = 1'b0;
    logic quiet = 1'b0;
    int   words_issued = 0;
    int   words_accepted = 0;
    int   words_checked = 0;
    int   error_count = 0;
    int   stuck_cycles = 0;
    int   settings_used = 0;
    int   phase_changes = 0;
    int   cuts_seen = 0;
    int   holds_seen = 0;

    traffic_phase_sequencer_with_preempt dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .range_raw      (range_raw),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .lamps          (lamps),
        .crossing_on    (crossing_on),
        .shown_distance (shown_distance),
        .current_phase  (current_phase),
        .seconds_left   (seconds_left)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic logic [CH_W-1:0] green_of(input logic [PHASE_W-1:0] p);
        return set_green[CH_W * p +: CH_W];
    endfunction

    function automatic logic train_close();
        return seq_dist < DIST_W'(set_near);
    endfunction

    function automatic light_word_t step_lights(input logic req, input logic [RANGE_W-1:0] raw);
        light_word_t     result;
        logic [CH_W-1:0] leaving;
        int              quot;
        begin
            if (req == REQ_HALF)
            begin
                if (seq_count == '0)
                begin
                    if (!((seq_phase == PHASE_1 || seq_phase == PHASE_2) && train_close())
                        || seq_next == PHASE_3)
                    begin
                        seq_cross = 1'b0;
                    end
                    seq_phase = seq_next;
                    seq_next  = seq_next + 1'b1;
                    seq_lamps = green_of(seq_phase);
                    seq_count = set_dwell[seq_phase];
                    phase_changes++;
                end
                else if (seq_count < BLINK_START)
                begin
                    leaving = green_of(seq_phase) & ~green_of(seq_next);
                    seq_lamps = seq_blink ? (seq_lamps | leaving) : (seq_lamps & ~leaving);
                    seq_blink = ~seq_blink;
                end
                if (seq_phase == PHASE_1 || seq_phase == PHASE_2)
                begin
                    seq_cross = train_close();
                end
            end
            else
            begin
                if (seq_count != '0)
                begin
                    seq_count = seq_count - 1'b1;
                    if (seq_count > CUT_TIME && train_close()
                        && (seq_phase == PHASE_0 || seq_phase == PHASE_3))
                    begin
                        seq_count = CUT_TIME;
                        seq_next  = PHASE_1;
                        cuts_seen++;
                    end
                    else if (seq_count < HOLD_TIME && train_close() && seq_phase == PHASE_2)
                    begin
                        seq_count = HOLD_TIME;
                        holds_seen++;
                    end
                end
                quot = int'(raw) / RANGE_STEP;
                seq_dist = (quot > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(quot);
            end
            result.lamp_word = seq_lamps;
            result.crossing  = seq_cross;
            result.distance  = seq_dist;
            result.phase     = seq_phase;
            result.seconds   = seq_count;
            return result;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
        begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
    endtask

    task automatic check_word(input light_word_t got);
        light_word_t want;
        begin
            if (pending_lights.size() == 0)
            begin
                report_mismatch($sformatf("result word with nothing expected (phase %0d)",
                                          got.phase));
                return;
            end
            want = pending_lights.pop_front();
            if (got.lamp_word !== want.lamp_word)
                report_mismatch($sformatf("word %0d lamps %h, expected %h",
                                          words_checked, got.lamp_word, want.lamp_word));
            if (got.crossing !== want.crossing)
                report_mismatch($sformatf("word %0d crossing_on %b, expected %b",
                                          words_checked, got.crossing, want.crossing));
            if (got.distance !== want.distance)
                report_mismatch($sformatf("word %0d shown_distance %0d, expected %0d",
                                          words_checked, got.distance, want.distance));
            if (got.phase !== want.phase)
                report_mismatch($sformatf("word %0d current_phase %0d, expected %0d",
                                          words_checked, got.phase, want.phase));
            if (got.seconds !== want.seconds)
                report_mismatch($sformatf("word %0d seconds_left %0d, expected %0d",
                                          words_checked, got.seconds, want.seconds));
            words_checked++;
        end
    endtask

    // Monitor: checks results first, then predicts for the accepted word.
    always @(posedge clk)
    begin
        light_word_t got;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got.lamp_word = lamps;
                got.crossing  = crossing_on;
                got.distance  = shown_distance;
                got.phase     = current_phase;
                got.seconds   = seconds_left;
                check_word(got);
            end
            if (in_valid && !in_stall)
            begin
                pending_lights.push_back(step_lights(req_type, range_raw));
                words_accepted++;
            end
            in_fire <= in_valid && !in_stall;
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles.", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Driver: a presented word holds until it is accepted.
    always @(negedge clk)
    begin
        tick_word_t word;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
            if (!in_valid || in_fire)
            begin
                if (tick_queue.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    word = tick_queue.pop_front();
                    in_valid  <= 1'b1;
                    req_type  <= word.req;
                    range_raw <= word.raw;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic queue_tick(input logic req, input logic [RANGE_W-1:0] raw);
        tick_word_t word;
        begin
            word.req = req;
            word.raw = raw;
            tick_queue.push_back(word);
            words_issued++;
        end
    endtask

    function automatic logic [RANGE_W-1:0] pick_range();
        int center;
        int value;
        begin
            case ($urandom_range(5))
                0: value = int'($urandom_range(RANGE_MAX));
                1: value = $urandom_range(1) ? RANGE_MAX : 0;
                5: value = DIST_MAX * RANGE_STEP + int'($urandom_range(40000)) - 20000;
                default:
                begin
                    center = int'(set_near) * RANGE_STEP;
                    value  = center + int'($urandom_range(60000)) - 30000;
                end
            endcase
            if (value < 0)
                value = 0;
            return RANGE_W'(value);
        end
    endfunction

    // Mostly whole seconds (two half ticks, then a second tick), some stray ticks.
    task automatic queue_traffic(input int count);
        int added;
        begin
            added = 0;
            while (added < count)
            begin
                if ($urandom_range(99) < 85)
                begin
                    queue_tick(REQ_HALF, RANGE_W'($urandom()));
                    queue_tick(REQ_HALF, RANGE_W'($urandom()));
                    queue_tick(REQ_SECOND, pick_range());
                    added += 3;
                end
                else
                begin
                    queue_tick($urandom_range(1) ? REQ_SECOND : REQ_HALF, pick_range());
                    added++;
                end
            end
        end
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_GREEN_PATTERN: set_green    = data;
            REG_DWELL_PHASE0:  set_dwell[0] = data[COUNT_W-1:0];
            REG_DWELL_PHASE1:  set_dwell[1] = data[COUNT_W-1:0];
            REG_DWELL_PHASE2:  set_dwell[2] = data[COUNT_W-1:0];
            REG_DWELL_PHASE3:  set_dwell[3] = data[COUNT_W-1:0];
            REG_NEAR_LIMIT:    set_near     = data[NEAR_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic program_all(input logic [PATTERN_W-1:0] green,
                               input logic [COUNT_W-1:0] d0, input logic [COUNT_W-1:0] d1,
                               input logic [COUNT_W-1:0] d2, input logic [COUNT_W-1:0] d3,
                               input logic [NEAR_W-1:0] near_value);
        program_reg(REG_GREEN_PATTERN, green);
        program_reg(REG_DWELL_PHASE0, {32'($urandom()), d0});
        program_reg(REG_DWELL_PHASE1, {32'($urandom()), d1});
        program_reg(REG_DWELL_PHASE2, {32'($urandom()), d2});
        program_reg(REG_DWELL_PHASE3, {32'($urandom()), d3});
        program_reg(REG_NEAR_LIMIT, {33'($urandom()), near_value});
        settings_used++;
    endtask

    function automatic logic [COUNT_W-1:0] pick_dwell();
        int roll;
        begin
            roll = $urandom_range(99);
            if (roll < 60)
                return COUNT_W'($urandom_range(6));
            else if (roll < 90)
                return COUNT_W'($urandom_range(30, 7));
            else if (roll < 95)
                return '0;
            return '1;
        end
    endfunction

    task automatic wait_idle();
        while (words_accepted != words_issued || pending_lights.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        set_green    = GREEN_PATTERN_RESET;
        set_dwell[0] = DWELL_RESET;
        set_dwell[1] = DWELL_RESET;
        set_dwell[2] = DWELL_RESET;
        set_dwell[3] = DWELL_RESET;
        set_near     = NEAR_LIMIT_RESET;
        seq_phase    = PHASE_0;
        seq_next     = PHASE_1;
        seq_count    = '0;
        seq_blink    = 1'b0;
        seq_dist     = DIST_RESET;
        seq_lamps    = '0;
        seq_cross    = 1'b0;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // A second tick straight after reset only samples the distance.
        queue_tick(REQ_SECOND, RANGE_W'(RANGE_MAX));
        wait_idle();

        // Zero dwell in phase 1, a short phase 2 for blinking; spare indexes are ignored.
        program_all(40'h9C3A5F0F96, 8'd5, 8'd0, 8'd2, 8'd7, 7'd20);
        program_reg(REG_SPARE_LO, '1);
        program_reg(REG_SPARE_HI, '1);
        queue_tick(REQ_SECOND, 24'd0);
        repeat (4) queue_tick(REQ_HALF, RANGE_W'($urandom()));
        queue_tick(REQ_SECOND, 24'd9999);
        queue_tick(REQ_SECOND, 24'd10000);
        queue_tick(REQ_SECOND, 24'd1009999);
        queue_tick(REQ_SECOND, 24'd999999);
        queue_tick(REQ_SECOND, 24'h800000);
        queue_tick(REQ_SECOND, 24'd1000000);
        queue_tick(REQ_HALF, 24'h000000);
        queue_tick(REQ_SECOND, 24'd700000);
        queue_tick(REQ_HALF, 24'hFFFFFF);
        queue_tick(REQ_HALF, 24'h555555);
        queue_tick(REQ_SECOND, 24'd123456);
        queue_tick(REQ_HALF, 24'hAAAAAA);
        queue_tick(REQ_HALF, 24'h000000);
        queue_tick(REQ_SECOND, 24'd654321);
        repeat (3) queue_tick(REQ_HALF, RANGE_W'($urandom()));
        queue_tick(REQ_SECOND, 24'd50000);
        wait_idle();

        // A long stretch with no gaps and no stalls.
        program_all({8'($urandom()), 32'($urandom())}, COUNT_W'($urandom_range(5, 1)),
                    COUNT_W'($urandom_range(5, 1)), COUNT_W'($urandom_range(5, 1)),
                    COUNT_W'($urandom_range(5, 1)), 7'd40);
        quiet = 1'b1;
        queue_traffic(150);
        wait_idle();
        quiet = 1'b0;

        // No train is ever near, all lamps dark, every phase one half tick long.
        program_all('0, 8'd0, 8'd0, 8'd0, 8'd0, 7'd0);
        queue_traffic(60);
        wait_idle();

        // Every train is near, all lamps green, longest dwell.
        program_all('1, 8'd255, 8'd255, 8'd255, 8'd255, 7'd101);
        queue_traffic(80);
        wait_idle();

        repeat (5)
        begin
            program_all({8'($urandom()), 32'($urandom())}, pick_dwell(), pick_dwell(),
                        pick_dwell(), pick_dwell(), NEAR_W'($urandom_range(101)));
            queue_traffic(90);
            wait_idle();
        end

        if (pending_lights.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived", pending_lights.size()));

        $display("Checked %0d result words from %0d tick words under %0d register settings.",
                 words_checked, words_accepted, settings_used);
        $display("Predicted %0d phase changes, %0d train cuts and %0d phase 2 holds.",
                 phase_changes, cuts_seen, holds_seen);
        if (error_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tps_pkg.sv
rtl/traffic_phase_sequencer_with_preempt.sv
verif/testbench.sv
